@@ rtl/slir_pkg.sv @@
// Shared types, codes and constants for the sorted insertion list.
package slir_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int COUNT_BITS   = 5;
	localparam int STATUS_BITS  = 2;
	localparam int CAPACITY_DEF = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

	// Request transaction.
	typedef struct packed {
		logic                         op;
		logic signed [VALUE_BITS-1:0] value;
	} slir_in_t;

	// Response transaction.
	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [COUNT_BITS-1:0]  count;
	} slir_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                   start;
		logic                   read;
		logic                   shift;
		logic                   place;
		logic                   rem_step;
		logic                   dec;
		logic                   emit;
		logic [STATUS_BITS-1:0] code;
	} slir_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic pos_zero;
		logic pos_last;
		logic ge;
		logic hit;
		logic found;
		logic out_free;
	} slir_stat_t;

endpackage

@@ rtl/slir_ctrl.sv @@
// Controller state machine that sequences inserts and removes over the entry memory.
module slir_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  slir_pkg::slir_stat_t    stat,
	output slir_pkg::slir_cmd_t     cmd
);
	import slir_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]             state_q, state_d;
	logic [STATUS_BITS-1:0] code_q, code_d;

	// A new request is taken only when no transaction is in progress.
	assign req_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.op == OP_INSERT) begin
					if (stat.full) begin
						code_d  = ST_FULL;
						state_d = S_FIN;
					end else if (stat.pos_zero) begin
						cmd.place = 1'b1;
						code_d    = ST_DONE;
						state_d   = S_FIN;
					end else begin
						state_d = S_RD;
					end
				end else begin
					if (stat.empty) begin
						code_d  = ST_NOT_FOUND;
						state_d = S_FIN;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.read = 1'b1;
				state_d  = S_EV;
			end
			S_EV: begin
				if (stat.op == OP_INSERT) begin
					// Entries not less than the new value move up one slot.
					if (stat.ge) begin
						cmd.shift = 1'b1;
						state_d   = S_CHK;
					end else begin
						cmd.place = 1'b1;
						code_d    = ST_DONE;
						state_d   = S_FIN;
					end
				end else begin
					cmd.rem_step = 1'b1;
					if (stat.pos_last) begin
						cmd.dec = stat.found | stat.hit;
						code_d  = (stat.found | stat.hit) ? ST_DONE : ST_NOT_FOUND;
						state_d = S_FIN;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

@@ rtl/slir_dp.sv @@
// Datapath: entry memory, count, scan position and the response register.
module slir_dp #(
	parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slir_pkg::slir_in_t    req_data,
	input  slir_pkg::slir_cmd_t   cmd,
	output slir_pkg::slir_stat_t  stat,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output slir_pkg::slir_out_t   rsp_data
);
	import slir_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic signed [VALUE_BITS-1:0] mem [CAPACITY];
	logic signed [VALUE_BITS-1:0] val_q;
	logic signed [VALUE_BITS-1:0] rdata_q;
	logic                         op_q;
	logic                         found_q;
	logic [CW-1:0]                pos_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                pos_m1;
	logic [AW-1:0]                raddr;
	logic [AW-1:0]                waddr;
	logic signed [VALUE_BITS-1:0] wdata;
	logic                         we;
	logic                         rsp_valid_q;
	slir_out_t                    rsp_q;

	assign pos_m1 = pos_q - CW'(1);

	// Insert reads the slot below the target, remove reads the scan slot.
	assign raddr = (op_q == OP_INSERT) ? pos_m1[AW-1:0] : pos_q[AW-1:0];

	// Write port: upward shift or placement on insert, downward shift on remove.
	always_comb begin
		we    = cmd.shift | cmd.place | (cmd.rem_step & found_q);
		waddr = pos_q[AW-1:0];
		wdata = rdata_q;
		if (cmd.place) begin
			wdata = val_q;
		end
		if (cmd.rem_step) begin
			waddr = pos_m1[AW-1:0];
		end
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.read) begin
			rdata_q <= mem[raddr];
		end
	end

	// Request payload is held for the whole transaction.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q <= req_data.value;
			op_q  <= req_data.op;
		end
	end

	// Scan position, match flag and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.start) begin
				pos_q   <= (req_data.op == OP_INSERT) ? cnt_q : '0;
				found_q <= 1'b0;
			end else if (cmd.shift) begin
				pos_q <= pos_m1;
			end else if (cmd.rem_step) begin
				pos_q <= pos_q + CW'(1);
				if (!found_q && (rdata_q == val_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.place) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Response register: loaded when the controller emits, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status <= cmd.code;
			rsp_q.count  <= COUNT_BITS'(cnt_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Status back to the controller.
	always_comb begin
		stat.op       = op_q;
		stat.full     = (cnt_q == CW'(CAPACITY));
		stat.empty    = (cnt_q == '0);
		stat.pos_zero = (pos_q == '0);
		stat.pos_last = (pos_q == cnt_q - CW'(1));
		stat.ge       = (rdata_q >= val_q);
		stat.hit      = (rdata_q == val_q);
		stat.found    = found_q;
		stat.out_free = !rsp_valid_q || !rsp_stall;
	end

endmodule

@@ rtl/sorted_list_insert_remove.sv @@
// Top level of the sorted insertion list: controller plus datapath.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_data  (op, value)
//   rsp      out  rsp_valid / rsp_stall  rsp_data  (status, count)
//
// One request is processed at a time. An insert moves up each entry not less than the
// new value and places the value in the freed slot, straight from the check state when
// it lands at the head; a remove scans every stored entry. A refused insert or a remove
// from an empty list goes from the check state to the final state. Each entry visited
// passes a read state, where the entry memory, whose data is registered, is read, and
// an evaluate state; an insert also passes the check state per moved entry. Reset
// clears the count and the handshake state; entry contents are not reset.
// A held response does not block acceptance of the next request; the result
// waits in the final state until the response register is free.
module sorted_list_insert_remove #(
	parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  slir_pkg::slir_in_t   req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output slir_pkg::slir_out_t  rsp_data
);
	import slir_pkg::*;

	slir_cmd_t  cmd;
	slir_stat_t stat;

	// Sequencer.
	slir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and response path.
	slir_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

`ifndef SYNTHESIS
	// An accepted request keeps the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side not busy after accepting a transaction");

	// The reported count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.count <= COUNT_BITS'(CAPACITY))
		else $error("response count above capacity");

	// A full status is only reported with a full list.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count == COUNT_BITS'(CAPACITY))
		else $error("full status with a list that is not full");

	// Status codes stay within the defined set.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status == ST_DONE || rsp_data.status == ST_NOT_FOUND
			|| rsp_data.status == ST_FULL)
		else $error("undefined response status");
`endif

endmodule
